FILE: rtl/mfps_pkg.sv
// ----------------------------------------------------------------------------
// Forbidden pattern scanner package
// Pattern table, reason codes and the byte folding function used by the top
// level, and the cell control type shared with the scanner cells.
// ----------------------------------------------------------------------------
package mfps_pkg;

  // Number of previous bytes held in the window.
  localparam int unsigned WinDepth   = 13;
  // The window plus the current byte.
  localparam int unsigned HistBytes  = WinDepth + 1;
  localparam int unsigned HistW      = 8 * HistBytes;

  // The https forms are left out: the http form always completes one byte
  // earlier and carries the same reason.
  localparam int unsigned NumPat     = 16;
  localparam int unsigned NumForbid  = 14;
  localparam int unsigned BitSvgOpen = 14;
  localparam int unsigned BitSvgClose = 15;

  // Verdict reason codes.
  typedef enum logic [3:0] {
    RSN_SAFE          = 4'd0,
    RSN_SCRIPT        = 4'd1,
    RSN_SCRIPT_CLOSE  = 4'd2,
    RSN_HTTP_HREF     = 4'd3,
    RSN_XLINK         = 4'd4,
    RSN_URL           = 4'd5,
    RSN_FOREIGN       = 4'd6,
    RSN_ONCLICK       = 4'd7,
    RSN_ONLOAD        = 4'd8,
    RSN_ONERROR       = 4'd9,
    RSN_ONMOUSEOVER   = 4'd10,
    RSN_NAN           = 4'd11,
    RSN_INFINITY      = 4'd12,
    RSN_INF           = 4'd13,
    RSN_MISSING_SVG   = 4'd14
  } reason_e;

  // Control that every window cell receives.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Pattern text, right aligned: the last character sits in the low byte.
  localparam logic [HistW-1:0] PatText [NumPat] = '{
    HistW'("<script"),
    HistW'("</script"),
    HistW'("href=\"http"),
    HistW'("href='http"),
    HistW'("xlink:href"),
    HistW'("url("),
    HistW'("<foreignobject"),
    HistW'("onclick="),
    HistW'("onload="),
    HistW'("onerror="),
    HistW'("onmouseover="),
    HistW'("nan"),
    HistW'("infinity"),
    HistW'("inf"),
    HistW'("<svg"),
    HistW'("</svg>")
  };

  localparam int unsigned PatLen [NumPat] = '{
    7, 8, 10, 10, 10, 4, 14, 8, 7, 8, 12, 3, 8, 3, 4, 6
  };

  localparam reason_e PatCode [NumForbid] = '{
    RSN_SCRIPT, RSN_SCRIPT_CLOSE, RSN_HTTP_HREF, RSN_HTTP_HREF, RSN_XLINK,
    RSN_URL, RSN_FOREIGN, RSN_ONCLICK, RSN_ONLOAD, RSN_ONERROR,
    RSN_ONMOUSEOVER, RSN_NAN, RSN_INFINITY, RSN_INF
  };

  // Fold ASCII upper case letters to lower case; all other bytes pass.
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Mask that selects the newest len bytes of the history word.
  function automatic logic [HistW-1:0] byte_mask(input int unsigned len);
    logic [HistW-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < HistBytes; i++) begin
      if (i < len) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/mfps_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one folded byte of the recent text and hands it to the next cell
// each time a byte is taken in; a clear returns it to zero.
// ----------------------------------------------------------------------------
module mfps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfps_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  output logic [7:0]          byte_o
);
  import mfps_pkg::*;

  logic [7:0] byte_d;
  logic [7:0] byte_q;

  // Zero matches no pattern, so a cleared cell never contributes a hit.
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/markup_forbidden_pattern_scanner.sv
// ----------------------------------------------------------------------------
// Markup forbidden pattern scanner
// Folds each text byte to lower case, matches all patterns in parallel on a
// chain of window cells and gives one verdict per text on its last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; every pattern
//   compare runs on the window in the cycle the byte is taken in.
// Output: the verdict is registered and appears in the cycle after the last
//   byte of a text is taken in.
// Reset: clears the window cells, the seen flags and the output valid.
module markup_forbidden_pattern_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_safe_o,
  output logic [3:0] reason_code_o
);
  import mfps_pkg::*;

  logic                  in_acc;
  logic [7:0]            cur_byte;
  logic [7:0]            win [WinDepth];
  logic [HistW-1:0]      hist;
  logic [NumPat-1:0]     hit;
  logic [NumPat-1:0]     seen_d;
  logic [NumPat-1:0]     seen_q;
  cell_ctrl_t            cell_ctrl;
  reason_e               verdict_code;
  logic                  verdict_safe;
  logic                  out_valid_d;
  logic                  out_valid_q;
  logic                  is_safe_q;
  reason_e               reason_q;

  // A transaction is taken whenever the output register is free or drains.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cur_byte   = fold_lower(text_byte_i);

  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.clear = in_acc && last_byte_i;

  // Chain of window cells, newest byte in cell zero.
  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    if (i == 0) begin : g_head
      mfps_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .byte_i (cur_byte),
        .byte_o (win[i])
      );
    end else begin : g_body
      mfps_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .byte_i (win[i-1]),
        .byte_o (win[i])
      );
    end
    assign hist[8*(i+1) +: 8] = win[i];
  end
  assign hist[7:0] = cur_byte;

  // Parallel compare of every pattern that ends on the current byte.
  always_comb begin
    for (int unsigned p = 0; p < NumPat; p++) begin
      hit[p] = ((hist ^ PatText[p]) & byte_mask(PatLen[p])) == '0;
    end
  end

  assign seen_d = seen_q | hit;

  // The forbidden pattern seen that stands first in the table sets the verdict; with none, the svg tag check decides.
  always_comb begin
    verdict_safe = 1'b0;
    verdict_code = RSN_MISSING_SVG;
    if (seen_d[BitSvgOpen] && seen_d[BitSvgClose]) begin
      verdict_safe = 1'b1;
      verdict_code = RSN_SAFE;
    end
    for (int k = NumForbid - 1; k >= 0; k--) begin
      if (seen_d[k]) begin
        verdict_safe = 1'b0;
        verdict_code = PatCode[k];
      end
    end
  end

  // Seen flags collect over a text and clear after its verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (in_acc) begin
      seen_q <= last_byte_i ? '0 : seen_d;
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc && last_byte_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      is_safe_q <= verdict_safe;
      reason_q  <= verdict_code;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_safe_o     = is_safe_q;
  assign reason_code_o = reason_q;

  // A verdict is presented in the cycle after the last byte is taken.
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> out_valid_o)
    else $error("verdict missing after last byte");

  // The flags start over after each text.
  a_flags_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> seen_q == '0)
    else $error("seen flags not cleared after verdict");

  // A safe verdict always carries the safe reason.
  a_safe_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_safe_o |-> reason_code_o == RSN_SAFE)
    else $error("safe verdict with a reason code");

  // Input only stalls on a pending verdict.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

endmodule
